// File: rtl/pbfc_pkg.sv
// ----------------------------------------------------------------------------
// pbfc_pkg: shared types and constants of the bank free coverage block
// Widths, command codes, register indexes, reset values and the token that
// travels down the chain of bank cells.
// ----------------------------------------------------------------------------
package pbfc_pkg;

    localparam int PAGE_W      = 36;
    localparam int SIZE_W      = 25;
    localparam int CNT_W       = 25;
    localparam int SEG_W       = 3;
    localparam int MASK_W      = 8;
    localparam int TRIG_W      = 32;
    localparam int CMD_W       = 2;
    localparam int BANKS_W     = 4;
    localparam int MAP_W       = 24;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 36;
    localparam int BANK_CNT_DEF = 8;
    // Bank bounds reach the base plus eight bank sizes, which needs one more bit.
    localparam int ADDR_W      = PAGE_W + 1;

    localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RANGE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EVAL    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RESTORE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BANKS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SEGMAP = 3'd4;

    localparam logic [SIZE_W-1:0]  RST_SIZE   = 25'd65536;
    localparam logic [BANKS_W-1:0] RST_BANKS  = 4'd8;
    localparam logic [MAP_W-1:0]   RST_SEGMAP = 24'd16434824;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [PAGE_W-1:0] range_start;
        logic [PAGE_W-1:0] range_end;
    } t_in_item;

    typedef struct packed {
        logic [MASK_W-1:0] segment_mask;
        logic [TRIG_W-1:0] trigger_count;
        logic              status;
    } t_out_item;

    typedef struct packed {
        logic              valid;
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] bank_start;
        logic [ADDR_W-1:0] bank_end;
        logic [MASK_W-1:0] mask;
    } t_tok;

endpackage

// File: rtl/pbfc_stream_if.sv
// ----------------------------------------------------------------------------
// pbfc_stream_if: valid/ready channel
// Carries one payload per transfer from a source to a sink.
// ----------------------------------------------------------------------------
interface pbfc_stream_if #(
    parameter type T_PAYLOAD = logic
) ();
    logic     valid;
    logic     ready;
    T_PAYLOAD payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/pbfc_cell.sv
// ----------------------------------------------------------------------------
// pbfc_cell: one bank of the coverage chain
// Holds the free-page counter of its bank, adds the clipped overlap of a
// range, clears on a clear token, folds its segment bit into an evaluate
// token when its counter equals the bank size, and hands the token to the next bank.
// ----------------------------------------------------------------------------
module pbfc_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pbfc_pkg::t_tok                i_tok,
    input  logic [pbfc_pkg::PAGE_W-1:0]   i_lo,
    input  logic [pbfc_pkg::PAGE_W-1:0]   i_hi,
    input  logic [pbfc_pkg::SIZE_W-1:0]   i_size,
    input  logic                          i_active,
    input  logic [pbfc_pkg::SEG_W-1:0]    i_seg,
    output pbfc_pkg::t_tok                o_tok
);

    logic [pbfc_pkg::CNT_W-1:0]  r_count;
    logic [pbfc_pkg::CNT_W-1:0]  r_ovl;
    logic                        r_add_v;
    pbfc_pkg::t_tok              r_tok;

    logic [pbfc_pkg::ADDR_W-1:0] w_lo;
    logic [pbfc_pkg::ADDR_W-1:0] w_hi;
    logic [pbfc_pkg::ADDR_W-1:0] w_a;
    logic [pbfc_pkg::ADDR_W-1:0] w_z;
    logic [pbfc_pkg::ADDR_W-1:0] w_diff;
    logic                        w_hit;
    logic [pbfc_pkg::CNT_W:0]    w_sum;
    logic                        w_full;

    assign w_lo   = pbfc_pkg::ADDR_W'(i_lo);
    assign w_hi   = pbfc_pkg::ADDR_W'(i_hi);
    assign w_a    = (i_tok.bank_start > w_lo) ? i_tok.bank_start : w_lo;
    assign w_z    = (i_tok.bank_end < w_hi) ? i_tok.bank_end : w_hi;
    assign w_diff = w_z - w_a;
    assign w_hit  = i_tok.valid && (i_tok.cmd == pbfc_pkg::CMD_RANGE) && i_active
                    && (w_z > w_a);
    assign w_sum  = {1'b0, r_count} + {1'b0, r_ovl};
    assign w_full = i_active && (r_count == i_size);

    always_ff @(posedge i_clk) begin
        r_ovl <= w_diff[pbfc_pkg::CNT_W-1:0];
        r_tok.cmd        <= i_tok.cmd;
        r_tok.bank_start <= i_tok.bank_end;
        r_tok.bank_end   <= i_tok.bank_end + pbfc_pkg::ADDR_W'(i_size);
        if (i_tok.cmd == pbfc_pkg::CMD_EVAL && w_full) begin
            r_tok.mask <= i_tok.mask | (pbfc_pkg::MASK_W'(1) << i_seg);
        end else begin
            r_tok.mask <= i_tok.mask;
        end
        if (!i_rst_n) begin
            r_count     <= '0;
            r_add_v     <= 1'b0;
            r_tok.valid <= 1'b0;
        end else begin
            r_add_v     <= w_hit;
            r_tok.valid <= i_tok.valid;
            if (i_tok.valid && i_tok.cmd == pbfc_pkg::CMD_CLEAR) begin
                r_count <= '0;
            end else if (r_add_v) begin
                r_count <= w_sum[pbfc_pkg::CNT_W] ? '1 : w_sum[pbfc_pkg::CNT_W-1:0];
            end
        end
    end

    assign o_tok = r_tok;

endmodule

// File: rtl/pasr_bank_free_coverage.sv
// ----------------------------------------------------------------------------
// pasr_bank_free_coverage: free-page coverage of equal-sized banks
// Clear, range and evaluate commands run as a token down a chain of bank
// cells; restore and commands met while disabled finish at once.
// Restore and any disabled command are answered straight from the idle
// state; clear, range and evaluate go through the launch, walk and done
// states, one item in flight at a time, so no new request is taken until the
// token has walked through the bank chain. A synchronous reset loads the register
// defaults and zeroes all counters, the mask and the trigger count.
// ----------------------------------------------------------------------------
module pasr_bank_free_coverage #(
    parameter int BANK_CNT = pbfc_pkg::BANK_CNT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [pbfc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [pbfc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    pbfc_stream_if.sink                      i_req,
    pbfc_stream_if.source                    o_rsp
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_LAUNCH = 2'd1;
    localparam logic [1:0] S_WALK   = 2'd2;
    localparam logic [1:0] S_DONE   = 2'd3;

    logic                            r_enable;
    logic [pbfc_pkg::PAGE_W-1:0]     r_base;
    logic [pbfc_pkg::SIZE_W-1:0]     r_size;
    logic [pbfc_pkg::BANKS_W-1:0]    r_banks;
    logic [pbfc_pkg::MAP_W-1:0]      r_segmap;

    logic [1:0]                      r_state, n_state;
    logic [pbfc_pkg::MASK_W-1:0]     r_mask, n_mask;
    logic [pbfc_pkg::TRIG_W-1:0]     r_trig, n_trig;
    logic                            r_out_v, n_out_v;
    pbfc_pkg::t_out_item             r_out, n_out;
    logic [pbfc_pkg::CMD_W-1:0]      r_cmd;
    logic [pbfc_pkg::PAGE_W-1:0]     r_lo;
    logic [pbfc_pkg::PAGE_W-1:0]     r_hi;
    logic [pbfc_pkg::MASK_W-1:0]     r_walk_mask;

    pbfc_pkg::t_in_item              w_in;
    pbfc_pkg::t_tok                  w_tok [0:BANK_CNT];
    logic [BANK_CNT:0]               w_tok_v;
    logic                            w_in_acc;
    logic                            w_out_free;

    assign w_in       = i_req.payload;
    assign w_out_free = !r_out_v || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE) && w_out_free;
    assign w_in_acc   = i_req.valid && (r_state == S_IDLE) && w_out_free;
    assign o_rsp.valid   = r_out_v;
    assign o_rsp.payload = r_out;

    assign w_tok[0].valid      = (r_state == S_LAUNCH);
    assign w_tok[0].cmd        = r_cmd;
    assign w_tok[0].bank_start = pbfc_pkg::ADDR_W'(r_base);
    assign w_tok[0].bank_end   = pbfc_pkg::ADDR_W'(r_base) + pbfc_pkg::ADDR_W'(r_size);
    assign w_tok[0].mask       = '0;
    assign w_tok_v[0]          = w_tok[0].valid;

    for (genvar g = 0; g < BANK_CNT; g++) begin : g_bank
        pbfc_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_tok    (w_tok[g]),
            .i_lo     (r_lo),
            .i_hi     (r_hi),
            .i_size   (r_size),
            .i_active (r_banks > pbfc_pkg::BANKS_W'(g)),
            .i_seg    (r_segmap[pbfc_pkg::SEG_W*g +: pbfc_pkg::SEG_W]),
            .o_tok    (w_tok[g+1])
        );
        assign w_tok_v[g+1] = w_tok[g+1].valid;
    end

    always_comb begin
        n_state = r_state;
        n_mask  = r_mask;
        n_trig  = r_trig;
        n_out_v = r_out_v && !o_rsp.ready;
        n_out   = r_out;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (!r_enable) begin
                        n_out_v             = 1'b1;
                        n_out.segment_mask  = r_mask;
                        n_out.trigger_count = r_trig;
                        n_out.status        = (w_in.cmd != pbfc_pkg::CMD_RESTORE);
                    end else if (w_in.cmd == pbfc_pkg::CMD_RESTORE) begin
                        n_mask              = '0;
                        n_out_v             = 1'b1;
                        n_out.segment_mask  = '0;
                        n_out.trigger_count = r_trig;
                        n_out.status        = 1'b0;
                    end else begin
                        n_state = S_LAUNCH;
                    end
                end
            end
            S_LAUNCH: begin
                n_state = S_WALK;
            end
            S_WALK: begin
                if (w_tok[BANK_CNT].valid) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state      = S_IDLE;
                    n_out_v      = 1'b1;
                    n_out.status = 1'b0;
                    if (r_cmd == pbfc_pkg::CMD_EVAL) begin
                        n_mask              = r_walk_mask;
                        n_trig              = r_trig + 1'b1;
                        n_out.segment_mask  = r_walk_mask;
                        n_out.trigger_count = r_trig + 1'b1;
                    end else begin
                        n_out.segment_mask  = r_mask;
                        n_out.trigger_count = r_trig;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (w_in_acc) begin
            r_cmd <= w_in.cmd;
            r_lo  <= w_in.range_start;
            r_hi  <= w_in.range_end;
        end
        if (w_tok[BANK_CNT].valid) begin
            r_walk_mask <= w_tok[BANK_CNT].mask;
        end
        if (!i_rst_n) begin
            r_enable <= 1'b1;
            r_base   <= '0;
            r_size   <= pbfc_pkg::RST_SIZE;
            r_banks  <= pbfc_pkg::RST_BANKS;
            r_segmap <= pbfc_pkg::RST_SEGMAP;
            r_state  <= S_IDLE;
            r_mask   <= '0;
            r_trig   <= '0;
            r_out_v  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mask  <= n_mask;
            r_trig  <= n_trig;
            r_out_v <= n_out_v;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pbfc_pkg::CFG_ENABLE: r_enable <= i_cfg_data[0];
                    pbfc_pkg::CFG_BASE:   r_base   <= i_cfg_data[pbfc_pkg::PAGE_W-1:0];
                    pbfc_pkg::CFG_SIZE:   r_size   <= i_cfg_data[pbfc_pkg::SIZE_W-1:0];
                    pbfc_pkg::CFG_BANKS:  r_banks  <= i_cfg_data[pbfc_pkg::BANKS_W-1:0];
                    pbfc_pkg::CFG_SEGMAP: r_segmap <= i_cfg_data[pbfc_pkg::MAP_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // At most one token travels through the chain.
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok_v))
        else $error("more than one token in the bank chain");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (w_tok_v == '0))
        else $error("token in the bank chain while idle");

    a_tok_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tok[BANK_CNT].valid |-> (r_state == S_WALK))
        else $error("token left the chain outside the walk");

    a_trig_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_DONE) |=> (r_trig == $past(r_trig)))
        else $error("trigger count moved outside the finishing step");

    a_mask_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_in_acc && r_state != S_DONE) |=> $stable(r_mask))
        else $error("segment mask changed without a command");

endmodule
